FILE: src/vtlm_pkg.sv
// Shared constants and register indexes for the video timing and layer mixer.
package vtlm_pkg;

	localparam int unsigned COLOR_W = 12;
	localparam int unsigned COORD_W = 8;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 12;

	localparam logic [COORD_W-1:0] VISIBLE_WIDTH = 8'd160;
	localparam logic [COORD_W-1:0] VISIBLE_LINES = 8'd152;
	localparam logic [COORD_W-1:0] LINE_TICKS = 8'd171;
	localparam logic [COORD_W-1:0] LAST_LINE_RESET = 8'd198;

	localparam logic [COLOR_W-1:0] NEGATE_MASK = 12'h007;

	localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODEL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND_ENABLE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND_COLOR = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NEGATE_SCREEN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LAST_LINE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HBLANK_IRQ_MASK = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_VBLANK_IRQ_MASK = 3'd6;

	localparam logic [1:0] SPRITE_PRIO_LOW = 2'd1;
	localparam logic [1:0] SPRITE_PRIO_MID = 2'd2;
	localparam logic [1:0] SPRITE_PRIO_HIGH = 2'd3;

endpackage

FILE: src/video_timing_and_layer_mixer.sv
// Top level: video timing counters, blank flags, interrupt levels and layer priority mixer.
//
// Each transaction on the input channel is one pixel-clock tick and yields exactly one
// transaction on the output channel. A tick is registered once, in the result
// register: the counter update and the priority mux sit between the tick inputs and that
// register, so one tick is taken every cycle as long as the output side keeps up; a
// stalled result holds the input side only while the result register is full and not taken.
// Lines are 171 ticks, the visible area is 160 by 152, and the frame wraps after the
// last_line register. Write configuration only while no tick is in flight.
module video_timing_and_layer_mixer (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [vtlm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [vtlm_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 plane_a_valid,
	input  logic                                 plane_a_prio,
	input  logic [vtlm_pkg::COLOR_W-1:0]         plane_a_color,
	input  logic                                 plane_b_valid,
	input  logic                                 plane_b_prio,
	input  logic [vtlm_pkg::COLOR_W-1:0]         plane_b_color,
	input  logic                                 sprite_valid,
	input  logic [1:0]                           sprite_prio,
	input  logic [vtlm_pkg::COLOR_W-1:0]         sprite_color,
	input  logic                                 window_valid,
	input  logic [vtlm_pkg::COLOR_W-1:0]         window_color,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 pixel_valid,
	output logic [vtlm_pkg::COLOR_W-1:0]         pixel_color,
	output logic [vtlm_pkg::COORD_W-1:0]         pixel_x,
	output logic [vtlm_pkg::COORD_W-1:0]         pixel_y,
	output logic                                 hblank_out,
	output logic                                 vblank_out,
	output logic                                 timer_line,
	output logic                                 vblank_irq_line,
	output logic                                 line_end,
	output logic                                 frame_end
);

	logic                            color_model_q;
	logic                            background_enable_q;
	logic [vtlm_pkg::COLOR_W-1:0]    background_color_q;
	logic                            negate_screen_q;
	logic [vtlm_pkg::COORD_W-1:0]    last_line_q;
	logic                            hblank_irq_mask_q;
	logic                            vblank_irq_mask_q;

	logic [vtlm_pkg::COORD_W-1:0]    hcount_q;
	logic [vtlm_pkg::COORD_W-1:0]    vcount_q;
	logic                            hblank_q;
	logic                            vblank_q;
	logic                            timer_level_q;
	logic                            int_level_q;

	logic                            out_valid_q;
	logic                            pixel_valid_q;
	logic [vtlm_pkg::COLOR_W-1:0]    pixel_color_q;
	logic [vtlm_pkg::COORD_W-1:0]    pixel_x_q;
	logic [vtlm_pkg::COORD_W-1:0]    pixel_y_q;
	logic                            line_end_q;
	logic                            frame_end_q;

	logic                            accept;
	logic                            visible;
	logic [vtlm_pkg::COLOR_W-1:0]    mix_color;
	logic [vtlm_pkg::COORD_W-1:0]    hcount_inc;
	logic [vtlm_pkg::COORD_W-1:0]    vcount_inc;
	logic [vtlm_pkg::COORD_W:0]      vcount_plus2;
	logic [vtlm_pkg::COORD_W-1:0]    hcount_d;
	logic [vtlm_pkg::COORD_W-1:0]    vcount_d;
	logic                            hblank_d;
	logic                            vblank_d;
	logic                            timer_level_d;
	logic                            int_level_d;
	logic                            line_end_d;
	logic                            frame_end_d;

	assign in_stall = out_valid_q & out_stall;
	assign accept = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_model_q <= 1'b0;
			background_enable_q <= 1'b0;
			background_color_q <= '0;
			negate_screen_q <= 1'b0;
			last_line_q <= vtlm_pkg::LAST_LINE_RESET;
			hblank_irq_mask_q <= 1'b0;
			vblank_irq_mask_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				vtlm_pkg::REG_COLOR_MODEL: color_model_q <= cfg_data[0];
				vtlm_pkg::REG_BACKGROUND_ENABLE: background_enable_q <= cfg_data[0];
				vtlm_pkg::REG_BACKGROUND_COLOR: background_color_q <= cfg_data;
				vtlm_pkg::REG_NEGATE_SCREEN: negate_screen_q <= cfg_data[0];
				vtlm_pkg::REG_LAST_LINE: last_line_q <= cfg_data[vtlm_pkg::COORD_W-1:0];
				vtlm_pkg::REG_HBLANK_IRQ_MASK: hblank_irq_mask_q <= cfg_data[0];
				vtlm_pkg::REG_VBLANK_IRQ_MASK: vblank_irq_mask_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign visible = (vcount_q < vtlm_pkg::VISIBLE_LINES) && (hcount_q < vtlm_pkg::VISIBLE_WIDTH);

	always_comb begin
		mix_color = '0;
		if (color_model_q && background_enable_q) mix_color = background_color_q;
		if (sprite_valid && sprite_prio == vtlm_pkg::SPRITE_PRIO_LOW) mix_color = sprite_color;
		if (plane_a_valid && !plane_a_prio) mix_color = plane_a_color;
		if (plane_b_valid && !plane_b_prio) mix_color = plane_b_color;
		if (sprite_valid && sprite_prio == vtlm_pkg::SPRITE_PRIO_MID) mix_color = sprite_color;
		if (plane_a_valid && plane_a_prio) mix_color = plane_a_color;
		if (plane_b_valid && plane_b_prio) mix_color = plane_b_color;
		if (sprite_valid && sprite_prio == vtlm_pkg::SPRITE_PRIO_HIGH) mix_color = sprite_color;
		if (window_valid) mix_color = window_color;
		if (!color_model_q && negate_screen_q) mix_color = mix_color ^ vtlm_pkg::NEGATE_MASK;
		if (!visible) mix_color = '0;
	end

	assign hcount_inc = hcount_q + 8'd1;
	assign vcount_inc = vcount_q + 8'd1;
	assign vcount_plus2 = {1'b0, vcount_q} + 9'd2;

	always_comb begin
		hcount_d = hcount_inc;
		vcount_d = vcount_q;
		hblank_d = hblank_q;
		vblank_d = vblank_q;
		timer_level_d = timer_level_q;
		int_level_d = int_level_q;
		line_end_d = 1'b0;
		frame_end_d = 1'b0;
		if (hcount_inc == vtlm_pkg::VISIBLE_WIDTH && vcount_q < vtlm_pkg::VISIBLE_LINES &&
				vcount_plus2 <= {1'b0, vtlm_pkg::VISIBLE_LINES}) begin
			hblank_d = 1'b1;
			timer_level_d = ~hblank_irq_mask_q;
		end
		if (hcount_inc >= vtlm_pkg::LINE_TICKS) begin
			line_end_d = 1'b1;
			hcount_d = '0;
			hblank_d = 1'b0;
			timer_level_d = 1'b1;
			vcount_d = vcount_inc;
			if (vcount_inc == vtlm_pkg::VISIBLE_LINES) begin
				vblank_d = 1'b1;
				int_level_d = ~vblank_irq_mask_q;
				frame_end_d = 1'b1;
			end
			if (vcount_inc == last_line_q) begin
				hblank_d = 1'b1;
				timer_level_d = ~hblank_irq_mask_q;
			end
			if (vcount_inc > last_line_q) begin
				vcount_d = '0;
				vblank_d = 1'b0;
				int_level_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hcount_q <= '0;
			vcount_q <= '0;
			hblank_q <= 1'b0;
			vblank_q <= 1'b0;
			timer_level_q <= 1'b1;
			int_level_q <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				hcount_q <= hcount_d;
				vcount_q <= vcount_d;
				hblank_q <= hblank_d;
				vblank_q <= vblank_d;
				timer_level_q <= timer_level_d;
				int_level_q <= int_level_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_valid_q <= visible;
			pixel_color_q <= mix_color;
			pixel_x_q <= hcount_q;
			pixel_y_q <= vcount_q;
			line_end_q <= line_end_d;
			frame_end_q <= frame_end_d;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_valid = pixel_valid_q;
	assign pixel_color = pixel_color_q;
	assign pixel_x = pixel_x_q;
	assign pixel_y = pixel_y_q;
	assign hblank_out = hblank_q;
	assign vblank_out = vblank_q;
	assign timer_line = timer_level_q;
	assign vblank_irq_line = int_level_q;
	assign line_end = line_end_q;
	assign frame_end = frame_end_q;

	a_hcount_range: assert property (@(posedge clk) disable iff (!arst_n)
		hcount_q < vtlm_pkg::LINE_TICKS)
		else $error("hcount left the line");

	a_visible_area: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && pixel_valid_q |->
			pixel_x_q < vtlm_pkg::VISIBLE_WIDTH && pixel_y_q < vtlm_pkg::VISIBLE_LINES)
		else $error("visible pixel outside the active area");

	a_blank_color: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !pixel_valid_q |-> pixel_color_q == '0)
		else $error("blank tick carries a color");

	a_line_end_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && line_end_q |-> pixel_x_q == vtlm_pkg::LINE_TICKS - 8'd1)
		else $error("line ended at the wrong tick");

	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && frame_end_q |->
			line_end_q && pixel_y_q == vtlm_pkg::VISIBLE_LINES - 8'd1)
		else $error("frame end off the last visible line");

endmodule

FILE: sim/video_timing_and_layer_mixer_tb.sv
`timescale 1ns / 100ps
// Testbench for video_timing_and_layer_mixer: layer priority, blanking, interrupt levels, frames.
module video_timing_and_layer_mixer_tb;

	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int unsigned RANDOM_TICKS_PER_PHASE = 150;
	localparam logic [vtlm_pkg::CFG_IDX_W-1:0] REG_OUT_OF_RANGE = 3'd7;
	localparam logic [1:0] SPRITE_HIDDEN = 2'd0;

	typedef struct packed {
		logic                          plane_a_valid;
		logic                          plane_a_prio;
		logic [vtlm_pkg::COLOR_W-1:0]  plane_a_color;
		logic                          plane_b_valid;
		logic                          plane_b_prio;
		logic [vtlm_pkg::COLOR_W-1:0]  plane_b_color;
		logic                          sprite_valid;
		logic [1:0]                    sprite_prio;
		logic [vtlm_pkg::COLOR_W-1:0]  sprite_color;
		logic                          window_valid;
		logic [vtlm_pkg::COLOR_W-1:0]  window_color;
	} tick_t;

	typedef struct packed {
		logic                          pixel_valid;
		logic [vtlm_pkg::COLOR_W-1:0]  pixel_color;
		logic [vtlm_pkg::COORD_W-1:0]  pixel_x;
		logic [vtlm_pkg::COORD_W-1:0]  pixel_y;
		logic                          hblank_out;
		logic                          vblank_out;
		logic                          timer_line;
		logic                          vblank_irq_line;
		logic                          line_end;
		logic                          frame_end;
	} pixel_t;

	typedef struct packed {
		logic                          color_model;
		logic                          background_enable;
		logic [vtlm_pkg::COLOR_W-1:0]  background_color;
		logic                          negate_screen;
		logic [vtlm_pkg::COORD_W-1:0]  last_line;
		logic                          hblank_irq_mask;
		logic                          vblank_irq_mask;
	} video_cfg_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [vtlm_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [vtlm_pkg::CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	tick_t tick_drv;
	logic out_valid;
	logic out_stall;
	pixel_t pixel_got;

	video_cfg_t video_cfg;
	logic [vtlm_pkg::COORD_W-1:0] h_count;
	logic [vtlm_pkg::COORD_W-1:0] v_count;
	logic hblank_flag;
	logic vblank_flag;
	logic timer_level;
	logic int_level;

	pixel_t expected_pixels[$];
	int unsigned error_count;
	int unsigned cycle_count;
	int unsigned send_idle_pct;
	int unsigned stall_pct;

	video_timing_and_layer_mixer i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.plane_a_valid  (tick_drv.plane_a_valid),
		.plane_a_prio   (tick_drv.plane_a_prio),
		.plane_a_color  (tick_drv.plane_a_color),
		.plane_b_valid  (tick_drv.plane_b_valid),
		.plane_b_prio   (tick_drv.plane_b_prio),
		.plane_b_color  (tick_drv.plane_b_color),
		.sprite_valid   (tick_drv.sprite_valid),
		.sprite_prio    (tick_drv.sprite_prio),
		.sprite_color   (tick_drv.sprite_color),
		.window_valid   (tick_drv.window_valid),
		.window_color   (tick_drv.window_color),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.pixel_valid    (pixel_got.pixel_valid),
		.pixel_color    (pixel_got.pixel_color),
		.pixel_x        (pixel_got.pixel_x),
		.pixel_y        (pixel_got.pixel_y),
		.hblank_out     (pixel_got.hblank_out),
		.vblank_out     (pixel_got.vblank_out),
		.timer_line     (pixel_got.timer_line),
		.vblank_irq_line(pixel_got.vblank_irq_line),
		.line_end       (pixel_got.line_end),
		.frame_end      (pixel_got.frame_end)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [vtlm_pkg::COLOR_W-1:0] mix_layers(tick_t t);
		logic [vtlm_pkg::COLOR_W-1:0] c;
		c = (video_cfg.color_model && video_cfg.background_enable) ?
			video_cfg.background_color : '0;
		if (t.sprite_valid && t.sprite_prio == vtlm_pkg::SPRITE_PRIO_LOW) c = t.sprite_color;
		if (t.plane_a_valid && !t.plane_a_prio) c = t.plane_a_color;
		if (t.plane_b_valid && !t.plane_b_prio) c = t.plane_b_color;
		if (t.sprite_valid && t.sprite_prio == vtlm_pkg::SPRITE_PRIO_MID) c = t.sprite_color;
		if (t.plane_a_valid && t.plane_a_prio) c = t.plane_a_color;
		if (t.plane_b_valid && t.plane_b_prio) c = t.plane_b_color;
		if (t.sprite_valid && t.sprite_prio == vtlm_pkg::SPRITE_PRIO_HIGH) c = t.sprite_color;
		if (t.window_valid) c = t.window_color;
		if (!video_cfg.color_model && video_cfg.negate_screen) c = c ^ vtlm_pkg::NEGATE_MASK;
		return c;
	endfunction

	function automatic pixel_t advance_pixel_clock(tick_t t);
		pixel_t p;
		logic [vtlm_pkg::COORD_W-1:0] next_h;
		p = '0;
		p.pixel_x = h_count;
		p.pixel_y = v_count;
		p.pixel_valid = (v_count < vtlm_pkg::VISIBLE_LINES) &&
			(h_count < vtlm_pkg::VISIBLE_WIDTH);
		p.pixel_color = p.pixel_valid ? mix_layers(t) : '0;
		next_h = h_count + 8'd1;
		if (next_h == vtlm_pkg::VISIBLE_WIDTH && v_count < vtlm_pkg::VISIBLE_LINES &&
				int'(v_count) + 2 <= int'(vtlm_pkg::VISIBLE_LINES)) begin
			hblank_flag = 1'b1;
			timer_level = ~video_cfg.hblank_irq_mask;
		end
		if (next_h >= vtlm_pkg::LINE_TICKS) begin
			p.line_end = 1'b1;
			next_h = '0;
			hblank_flag = 1'b0;
			timer_level = 1'b1;
			v_count = v_count + 8'd1;
			if (v_count == vtlm_pkg::VISIBLE_LINES) begin
				vblank_flag = 1'b1;
				int_level = ~video_cfg.vblank_irq_mask;
				p.frame_end = 1'b1;
			end
			if (v_count == video_cfg.last_line) begin
				hblank_flag = 1'b1;
				timer_level = ~video_cfg.hblank_irq_mask;
			end
			if (v_count > video_cfg.last_line) begin
				v_count = '0;
				vblank_flag = 1'b0;
				int_level = 1'b1;
			end
		end
		h_count = next_h;
		p.hblank_out = hblank_flag;
		p.vblank_out = vblank_flag;
		p.timer_line = timer_level;
		p.vblank_irq_line = int_level;
		return p;
	endfunction

	function automatic tick_t make_tick(bit av, bit ap, logic [vtlm_pkg::COLOR_W-1:0] ac,
			bit bv, bit bp, logic [vtlm_pkg::COLOR_W-1:0] bc, bit sv, logic [1:0] sp,
			logic [vtlm_pkg::COLOR_W-1:0] sc, bit wv, logic [vtlm_pkg::COLOR_W-1:0] wc);
		tick_t t;
		t.plane_a_valid = av;
		t.plane_a_prio = ap;
		t.plane_a_color = ac;
		t.plane_b_valid = bv;
		t.plane_b_prio = bp;
		t.plane_b_color = bc;
		t.sprite_valid = sv;
		t.sprite_prio = sp;
		t.sprite_color = sc;
		t.window_valid = wv;
		t.window_color = wc;
		return t;
	endfunction

	function automatic tick_t random_tick();
		return make_tick(1'($urandom_range(1)), 1'($urandom_range(1)),
			vtlm_pkg::COLOR_W'($urandom_range(4095)),
			1'($urandom_range(1)), 1'($urandom_range(1)),
			vtlm_pkg::COLOR_W'($urandom_range(4095)),
			1'($urandom_range(1)), 2'($urandom_range(3)),
			vtlm_pkg::COLOR_W'($urandom_range(4095)),
			$urandom_range(3) == 0, vtlm_pkg::COLOR_W'($urandom_range(4095)));
	endfunction

	// fill the bits above a register's width with noise
	function automatic logic [vtlm_pkg::CFG_DATA_W-1:0] with_noise(int unsigned width,
			int unsigned value);
		logic [vtlm_pkg::CFG_DATA_W-1:0] mask;
		mask = (vtlm_pkg::CFG_DATA_W'(1) << width) - vtlm_pkg::CFG_DATA_W'(1);
		return (vtlm_pkg::CFG_DATA_W'($urandom) & ~mask) |
			(vtlm_pkg::CFG_DATA_W'(value) & mask);
	endfunction

	task automatic cfg_write(logic [vtlm_pkg::CFG_IDX_W-1:0] idx,
			logic [vtlm_pkg::CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			vtlm_pkg::REG_COLOR_MODEL: video_cfg.color_model = data[0];
			vtlm_pkg::REG_BACKGROUND_ENABLE: video_cfg.background_enable = data[0];
			vtlm_pkg::REG_BACKGROUND_COLOR: video_cfg.background_color = data;
			vtlm_pkg::REG_NEGATE_SCREEN: video_cfg.negate_screen = data[0];
			vtlm_pkg::REG_LAST_LINE: video_cfg.last_line = data[vtlm_pkg::COORD_W-1:0];
			vtlm_pkg::REG_HBLANK_IRQ_MASK: video_cfg.hblank_irq_mask = data[0];
			vtlm_pkg::REG_VBLANK_IRQ_MASK: video_cfg.vblank_irq_mask = data[0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic apply_config(video_cfg_t c);
		wait_drained();
		cfg_write(vtlm_pkg::REG_COLOR_MODEL, with_noise(1, c.color_model));
		cfg_write(vtlm_pkg::REG_BACKGROUND_ENABLE, with_noise(1, c.background_enable));
		cfg_write(vtlm_pkg::REG_BACKGROUND_COLOR, c.background_color);
		cfg_write(vtlm_pkg::REG_NEGATE_SCREEN, with_noise(1, c.negate_screen));
		cfg_write(vtlm_pkg::REG_LAST_LINE, with_noise(vtlm_pkg::COORD_W, c.last_line));
		cfg_write(vtlm_pkg::REG_HBLANK_IRQ_MASK, with_noise(1, c.hblank_irq_mask));
		cfg_write(vtlm_pkg::REG_VBLANK_IRQ_MASK, with_noise(1, c.vblank_irq_mask));
		cfg_write(REG_OUT_OF_RANGE, vtlm_pkg::CFG_DATA_W'($urandom));
		cfg_we <= 1'b0;
	endtask

	task automatic send_tick(tick_t t);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			tick_drv <= random_tick();
			@(negedge clk);
		end
		in_valid <= 1'b1;
		tick_drv <= t;
		do @(posedge clk); while (in_stall);
		expected_pixels.push_back(advance_pixel_clock(t));
		@(negedge clk);
	endtask

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endtask

	always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

	always @(posedge clk) begin : check_pixels
		pixel_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_pixels.size() == 0) begin
				$error("pixel transaction with nothing expected");
				error_count++;
			end else begin
				want = expected_pixels.pop_front();
				check_field("pixel_valid", want.pixel_valid, pixel_got.pixel_valid);
				check_field("pixel_color", want.pixel_color, pixel_got.pixel_color);
				check_field("pixel_x", want.pixel_x, pixel_got.pixel_x);
				check_field("pixel_y", want.pixel_y, pixel_got.pixel_y);
				check_field("hblank_out", want.hblank_out, pixel_got.hblank_out);
				check_field("vblank_out", want.vblank_out, pixel_got.vblank_out);
				check_field("timer_line", want.timer_line, pixel_got.timer_line);
				check_field("vblank_irq_line", want.vblank_irq_line,
					pixel_got.vblank_irq_line);
				check_field("line_end", want.line_end, pixel_got.line_end);
				check_field("frame_end", want.frame_end, pixel_got.frame_end);
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Test completed with failures");
		$finish;
	end

	task automatic test_layer_priority();
		video_cfg_t c;
		c = '{color_model: 1'b0, background_enable: 1'b0, background_color: 12'h000,
			negate_screen: 1'b0, last_line: vtlm_pkg::LAST_LINE_RESET, hblank_irq_mask: 1'b0,
			vblank_irq_mask: 1'b0};
		apply_config(c);
		send_tick(make_tick(0, 0, 0, 0, 0, 0, 0, SPRITE_HIDDEN, 0, 0, 0));
		send_tick(make_tick(0, 0, 0, 0, 0, 0, 1, SPRITE_HIDDEN, 12'hfff, 0, 0));
		send_tick(make_tick(0, 0, 0, 0, 0, 0, 1, vtlm_pkg::SPRITE_PRIO_LOW, 12'h123, 0, 0));
		send_tick(make_tick(1, 0, 12'h456, 0, 0, 0, 1, vtlm_pkg::SPRITE_PRIO_LOW, 12'h123,
			0, 0));
		send_tick(make_tick(1, 0, 12'h456, 1, 0, 12'h789, 1, vtlm_pkg::SPRITE_PRIO_LOW,
			12'h123, 0, 0));
		send_tick(make_tick(0, 0, 0, 1, 0, 12'h789, 1, vtlm_pkg::SPRITE_PRIO_MID, 12'habc,
			0, 0));
		send_tick(make_tick(1, 1, 12'hdef, 1, 0, 12'h789, 1, vtlm_pkg::SPRITE_PRIO_MID,
			12'habc, 0, 0));
		send_tick(make_tick(1, 1, 12'hdef, 1, 1, 12'h0f0, 0, vtlm_pkg::SPRITE_PRIO_HIGH,
			12'hfff, 0, 0));
		send_tick(make_tick(1, 1, 12'hdef, 1, 1, 12'h0f0, 1, vtlm_pkg::SPRITE_PRIO_HIGH,
			12'hfff, 0, 0));
		send_tick(make_tick(1, 1, 12'hfff, 1, 1, 12'hfff, 1, vtlm_pkg::SPRITE_PRIO_HIGH,
			12'hfff, 1, 12'h000));
		send_tick(make_tick(1, 1, 12'hfff, 1, 1, 12'hfff, 1, vtlm_pkg::SPRITE_PRIO_HIGH,
			12'hfff, 1, 12'hfff));
		c.color_model = 1'b1;
		c.background_enable = 1'b1;
		c.background_color = 12'hfff;
		c.negate_screen = 1'b1;
		apply_config(c);
		send_tick(make_tick(0, 0, 0, 0, 0, 0, 0, SPRITE_HIDDEN, 0, 0, 0));
		send_tick(make_tick(0, 0, 0, 0, 0, 0, 1, SPRITE_HIDDEN, 12'h0a5, 0, 0));
		send_tick(make_tick(1, 0, 12'h000, 0, 0, 0, 0, SPRITE_HIDDEN, 0, 0, 0));
		send_tick(make_tick(0, 0, 0, 0, 0, 0, 0, SPRITE_HIDDEN, 0, 1, 12'h0a5));
		c.color_model = 1'b0;
		c.background_color = 12'h5a5;
		apply_config(c);
		send_tick(make_tick(0, 0, 0, 0, 0, 0, 0, SPRITE_HIDDEN, 0, 0, 0));
		send_tick(make_tick(0, 0, 0, 0, 0, 0, 0, SPRITE_HIDDEN, 0, 1, 12'hfff));
		send_tick(make_tick(0, 0, 0, 1, 1, 12'h5a5, 0, SPRITE_HIDDEN, 0, 0, 0));
	endtask

	task automatic run_random_ticks(int unsigned count);
		for (int unsigned i = 0; i < count; i++) begin
			if ($urandom_range(59) == 0) wait_drained();
			send_tick(random_tick());
		end
	endtask

	task automatic test_random_traffic();
		video_cfg_t c;
		c = '{color_model: 1'b0, background_enable: 1'b1, background_color: 12'hfff,
			negate_screen: 1'b1, last_line: vtlm_pkg::LAST_LINE_RESET, hblank_irq_mask: 1'b1,
			vblank_irq_mask: 1'b0};
		apply_config(c);
		send_idle_pct = 26;
		stall_pct = 64;
		run_random_ticks(RANDOM_TICKS_PER_PHASE);
		c = '{color_model: 1'b1, background_enable: 1'b1,
			background_color: vtlm_pkg::COLOR_W'($urandom), negate_screen: 1'b1,
			last_line: vtlm_pkg::LAST_LINE_RESET, hblank_irq_mask: 1'b0,
			vblank_irq_mask: 1'b1};
		apply_config(c);
		send_idle_pct = 64;
		stall_pct = 26;
		run_random_ticks(RANDOM_TICKS_PER_PHASE);
		c = '{color_model: 1'b1, background_enable: 1'b0, background_color: 12'h000,
			negate_screen: 1'b0, last_line: vtlm_pkg::LAST_LINE_RESET,
			hblank_irq_mask: 1'($urandom_range(1)), vblank_irq_mask: 1'($urandom_range(1))};
		apply_config(c);
		send_idle_pct = 0;
		stall_pct = 0;
		run_random_ticks(RANDOM_TICKS_PER_PHASE);
	endtask

	task automatic run_frames(logic [vtlm_pkg::COORD_W-1:0] last, bit hmask, bit vmask,
			int unsigned lines);
		video_cfg_t c;
		c = '{color_model: 1'($urandom_range(1)), background_enable: 1'($urandom_range(1)),
			background_color: vtlm_pkg::COLOR_W'($urandom),
			negate_screen: 1'($urandom_range(1)),
			last_line: last, hblank_irq_mask: hmask, vblank_irq_mask: vmask};
		apply_config(c);
		for (int unsigned i = 0; i < lines * vtlm_pkg::LINE_TICKS; i++)
			send_tick(random_tick());
	endtask

	task automatic test_frame_timing();
		send_idle_pct = 0;
		stall_pct = 0;
		// frame shorter than the visible area: vblank is never entered
		run_frames(8'd2, 1'b1, 1'b0, 2);
		run_frames(8'd3, 1'b0, 1'b1, 2);
	endtask

	initial begin
		error_count = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		tick_drv = '0;
		video_cfg = '{color_model: 1'b0, background_enable: 1'b0, background_color: '0,
			negate_screen: 1'b0, last_line: vtlm_pkg::LAST_LINE_RESET, hblank_irq_mask: 1'b0,
			vblank_irq_mask: 1'b0};
		h_count = '0;
		v_count = '0;
		hblank_flag = 1'b0;
		vblank_flag = 1'b0;
		timer_level = 1'b1;
		int_level = 1'b1;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_layer_priority();
		test_random_traffic();
		test_frame_timing();

		wait_drained();
		repeat (10) @(posedge clk);
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

FILE: video_timing_and_layer_mixer.f
src/vtlm_pkg.sv
src/video_timing_and_layer_mixer.sv
sim/video_timing_and_layer_mixer_tb.sv
